// ----- src/dlr_pkg.sv -----
// Shared types and constants for the DDA line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

   // Coordinate and fixed-point widths
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
   localparam int QUO_BITS   = FRAC_BITS + 1;   // increment magnitude is at most 1.0
   localparam int INC_BITS   = FRAC_BITS + 2;   // signed increment

   // One half in the accumulator format, used for round-to-nearest
   localparam logic [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   // Classified item, as it waits between front and back
   typedef struct packed {
      op_type    op;
      logic      zero_len;
      logic      steep;
      coord_type major_pos;
      coord_type major_end;
      logic      major_dir_neg;
      coord_type minor_start;
      logic      minor_neg;
      coord_type major_mag;
      coord_type minor_mag;
   } item_type;

   // Slope divider request and response
   typedef struct packed {
      logic      start;
      coord_type num;
      coord_type den;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [QUO_BITS-1:0] quo;
   } div_rsp_type;

   // Back-end sequencer states
   typedef enum logic {
      BK_RUN = 1'b0,
      BK_DIV = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

// ----- src/dlr_front.sv -----
// Front end: classifies incoming beats and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module dlr_front import dlr_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_push,
   output logic           req_full,
   input  wire logic      req_op,
   input  wire coord_type req_start_x,
   input  wire coord_type req_start_y,
   input  wire coord_type req_end_x,
   input  wire coord_type req_end_y,
   output item_type       head,
   output logic           head_valid,
   input  wire logic      head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [COORD_BITS:0] dx, dy;
   coord_type           mag_dx, mag_dy;
   logic                steep;
   item_type            item;

   item_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push_ok, pop_ok;

   // Deltas and axis selection
   always_comb begin
      dx     = {1'b0, req_end_x} - {1'b0, req_start_x};
      dy     = {1'b0, req_end_y} - {1'b0, req_start_y};
      mag_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      mag_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      steep  = mag_dy > mag_dx;
   end

   // Build the classified item
   always_comb begin
      item.op       = op_type'(req_op);
      item.zero_len = (dx == '0) && (dy == '0);
      item.steep    = steep;
      if (steep) begin
         item.major_pos     = req_start_y;
         item.major_end     = req_end_y;
         item.major_dir_neg = dy[COORD_BITS];
         item.minor_start   = req_start_x;
         item.minor_neg     = dx[COORD_BITS];
         item.major_mag     = mag_dy;
         item.minor_mag     = mag_dx;
      end else begin
         item.major_pos     = req_start_x;
         item.major_end     = req_end_x;
         item.major_dir_neg = dx[COORD_BITS];
         item.minor_start   = req_start_y;
         item.minor_neg     = dy[COORD_BITS];
         item.major_mag     = mag_dx;
         item.minor_mag     = mag_dy;
      end
   end

   // Queue control
   assign req_full   = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

// ----- src/dlr_div.sv -----
// Restoring divider for the minor-axis slope, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dlr_div import dlr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(QUO_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [COORD_BITS:0] rem_ff, rem_in;
   coord_type           den_ff, den_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic                ge;
   logic [COORD_BITS:0] diff;

   // The remainder stays below the divisor, so the shifted value fits
   always_comb begin
      ge   = rem_ff >= {1'b0, den_ff};
      diff = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      priority if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_BITS);
         rem_in  = {1'b0, div_req.num};
         den_in  = div_req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = {diff[COORD_BITS-1:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // idle: hold
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

`default_nettype wire

// ----- src/dlr_back.sv -----
// Back end: segment state, pixel stepping and the result register.
`timescale 1ns / 1ps
`default_nettype none

module dlr_back import dlr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire item_type    head,
   input  wire logic        head_valid,
   output logic             head_pop,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output coord_type        rsp_point_x,
   output coord_type        rsp_point_y,
   output logic             rsp_last_point
);

   back_state_type        state_ff, state_in;

   logic                  active_ff, active_in;
   logic                  steep_ff;
   coord_type             major_pos_ff, major_pos_in;
   coord_type             major_end_ff;
   logic                  major_dir_neg_ff;
   logic                  minor_neg_ff;
   logic [ACC_BITS-1:0]   minor_acc_ff, minor_acc_in;
   logic [INC_BITS-1:0]   minor_inc_ff, minor_inc_in;

   logic                  out_valid_ff, out_valid_in;
   coord_type             out_x_ff, out_y_ff;
   logic                  out_last_ff;

   logic                  out_free;
   logic                  load_start, clear_active, emit;
   logic                  last;
   logic [ACC_BITS-1:0]   rounded;
   coord_type             minor;
   logic [INC_BITS-1:0]   quo_ext;

   assign out_free = !out_valid_ff || rsp_pop;
   assign last     = (major_pos_ff == major_end_ff);
   assign rounded  = minor_acc_ff + ACC_HALF;
   assign minor    = rounded[FRAC_BITS +: COORD_BITS];
   assign quo_ext  = {1'b0, div_rsp.quo};

   // Sequencer outputs
   always_comb begin
      head_pop      = 1'b0;
      load_start    = 1'b0;
      clear_active  = 1'b0;
      emit          = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = head.minor_mag;
      div_req.den   = head.major_mag;
      unique case (state_ff)
         BK_RUN: begin
            if (head_valid) begin
               unique case (head.op)
                  OP_START: begin
                     head_pop = 1'b1;
                     if (head.zero_len) begin
                        clear_active = 1'b1;
                     end else begin
                        load_start    = 1'b1;
                        div_req.start = 1'b1;
                     end
                  end
                  OP_STEP: begin
                     // a step with no segment is dropped
                     if (!active_ff) begin
                        head_pop = 1'b1;
                     end else if (out_free) begin
                        head_pop = 1'b1;
                        emit     = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_DIV: ;
         default: ;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_RUN: if (load_start) begin
            state_in = BK_DIV;
         end
         BK_DIV: if (div_rsp.done) begin
            state_in = BK_RUN;
         end
         default: state_in = BK_RUN;
      endcase
   end

   // Segment state updates
   always_comb begin
      active_in    = active_ff;
      major_pos_in = major_pos_ff;
      minor_acc_in = minor_acc_ff;
      minor_inc_in = minor_inc_ff;
      priority if (load_start || clear_active) begin
         active_in    = 1'b0;
         major_pos_in = head.major_pos;
         minor_acc_in = {1'b0, head.minor_start, {FRAC_BITS{1'b0}}};
      end else if (state_ff == BK_DIV && div_rsp.done) begin
         active_in    = 1'b1;
         minor_inc_in = minor_neg_ff ? -quo_ext : quo_ext;
      end else if (emit) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            major_pos_in = major_dir_neg_ff ? major_pos_ff - 1'b1 : major_pos_ff + 1'b1;
            minor_acc_in = minor_acc_ff
                         + {{(ACC_BITS - INC_BITS){minor_inc_ff[INC_BITS-1]}}, minor_inc_ff};
         end
      end else begin
         active_in = active_ff;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff <= major_pos_in;
      minor_acc_ff <= minor_acc_in;
      minor_inc_ff <= minor_inc_in;
      if (load_start) begin
         steep_ff         <= head.steep;
         major_end_ff     <= head.major_end;
         major_dir_neg_ff <= head.major_dir_neg;
         minor_neg_ff     <= head.minor_neg;
      end
      if (emit) begin
         out_x_ff    <= steep_ff ? minor : major_pos_ff;
         out_y_ff    <= steep_ff ? major_pos_ff : minor;
         out_last_ff <= last;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_point_x    = out_x_ff;
   assign rsp_point_y    = out_y_ff;
   assign rsp_last_point = out_last_ff;

endmodule

`default_nettype wire

// ----- src/dda_line_rasterizer_top.sv -----
// Top level of the DDA line rasterizer: front queue, slope divider, back end.
//
// Usage: push beats on the req_ side while req_full is low. A start beat
// (req_op = 0) loads the segment endpoints and yields no point; a step beat
// (req_op = 1) yields the next pixel of the active segment, from the start
// point through the end point, with rsp_last_point set on the end point.
// Steps with no active segment, and any segment of zero length, yield nothing.
// Results appear on the rsp_ side while rsp_empty is low; rsp_pop takes one.
// Throughput: one step beat per cycle while rsp_pop keeps the result register
// free. A start beat holds the back end while the serial divider works out
// the slope, one quotient bit per cycle; beats keep filling the front queue
// (QUEUE_DEPTH entries) meanwhile. A step beat passes through the front queue
// and then the result register on its way to the result ports.
// Reset clears the queue, the segment and the result register.
// When rsp_pop stays low the result register holds, the back end stops, and
// the queue fills until req_full rises.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer_top import dlr_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_push,
   output logic           req_full,
   input  wire logic      req_op,
   input  wire coord_type req_start_x,
   input  wire coord_type req_start_y,
   input  wire coord_type req_end_x,
   input  wire coord_type req_end_y,
   output logic           rsp_empty,
   input  wire logic      rsp_pop,
   output coord_type      rsp_point_x,
   output coord_type      rsp_point_y,
   output logic           rsp_last_point
);

   item_type    head;
   logic        head_valid;
   logic        head_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   dlr_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_op      (req_op),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .head        (head),
      .head_valid  (head_valid),
      .head_pop    (head_pop)
   );

   dlr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dlr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (head_valid),
      .head_pop       (head_pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

   // The back end only takes beats that are waiting in the queue
   a_pop_needs_head : assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("back end popped an empty queue");

   // A slope division starts only on a start beat, with the divider idle
   a_div_start : assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (!div_rsp.busy && head_pop && head.op == OP_START))
      else $error("divider started out of turn");

   // No new beat is taken in the cycle the slope result comes back
   a_done_no_pop : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> !head_pop)
      else $error("beat consumed while slope was pending");

   // A result cannot appear while the divider is running
   a_no_point_during_div : assert property (@(posedge clock) disable iff (reset)
      (div_rsp.busy && rsp_empty) |=> rsp_empty)
      else $error("point emitted during slope division");

endmodule

`default_nettype wire
